// ===== design/address_resolution_cache_defines.svh =====
// Assertion macros for the address resolution cache checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef ADDRESS_RESOLUTION_CACHE_DEFINES_SVH
`define ADDRESS_RESOLUTION_CACHE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define ARC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ARC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/arc_pkg.sv =====
package arc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int PA_MAX_BYTES  = 8;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int MODE_W  = 3;
  localparam int PT_W    = 16;
  localparam int PA_W    = 64;
  localparam int PAL_W   = 4;
  localparam int HA_W    = 48;
  localparam int ST_W    = 3;
  localparam int SHAMT_W = $clog2(PA_W) + 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-3:0] REG_TABLE_PTYPE = '0;

  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_PA = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_HA = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_TYPE      = 3'd4;

  typedef struct packed {
    logic [PA_W-1:0]  pa;
    logic [PAL_W-1:0] len;
    logic [HA_W-1:0]  ha;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PT_W-1:0]   ptype;
    logic [PA_W-1:0]   pa;
    logic [PAL_W-1:0]  len;
    logic [HA_W-1:0]   ha;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PA_W-1:0]  pa;
    logic [PAL_W-1:0] len;
    logic [HA_W-1:0]  ha;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

  // keep the first len bytes, counted from the top
  function automatic logic [PA_W-1:0] pa_mask(input logic [PA_W-1:0] value,
                                              input logic [PAL_W-1:0] len);
    logic [SHAMT_W-1:0] shamt;
    shamt = SHAMT_W'(PA_W) - SHAMT_W'({len, 3'b000});
    return value & ({PA_W{1'b1}} << shamt);
  endfunction

endpackage

// ===== design/arc_channels.sv =====
interface arc_in_if import arc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PT_W-1:0]   ptype;
  logic [PA_W-1:0]   pa_value;
  logic [PAL_W-1:0]  pa_length;
  logic [HA_W-1:0]   ha_value;

  modport source (output valid, mode, ptype, pa_value, pa_length, ha_value, input ready);
  modport sink (input valid, mode, ptype, pa_value, pa_length, ha_value, output ready);
endinterface

interface arc_out_if import arc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [PA_W-1:0]  found_pa;
  logic [PAL_W-1:0] found_pa_length;
  logic [HA_W-1:0]  found_ha;

  modport source (output valid, status, found_pa, found_pa_length, found_ha, input ready);
  modport sink (input valid, status, found_pa, found_pa_length, found_ha, output ready);
endinterface

// ===== design/arc_store.sv =====
module arc_store import arc_pkg::*; (
  input  logic       clk,
  input  store_req_t st_req,
  output entry_t     rd_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (st_req.we) begin
      mem[st_req.waddr] <= st_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (st_req.re) begin
      rd_data_r <= mem[st_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/arc_ctrl.sv =====
module arc_ctrl import arc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_rsp,
  input  logic [PT_W-1:0]  table_ptype,
  output store_req_t       st_req,
  input  entry_t           rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             issue_done_r, issue_done_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  entry_t           hit_ent_r, hit_ent_nxt;
  logic [IDX_W-1:0] sh_idx_r, sh_idx_nxt;
  rsp_t             rsp_r, rsp_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_rsp_r, out_rsp_nxt;

  logic             accept;
  logic             pa_eq;
  logic             ha_eq;
  logic             match;
  logic             len_bad;
  logic [CNT_W-1:0] last_c;
  entry_t           new_ent;
  entry_t           upd_ent;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign pa_eq   = (rd_data.len == req_r.len) && (rd_data.pa == req_r.pa);
  assign ha_eq   = (rd_data.ha == req_r.ha);
  assign len_bad = (in_req.mode != MODE_FIND_PA) &&
                   ((in_req.len == '0) || (in_req.len > PAL_W'(PA_MAX_BYTES)));
  assign last_c  = cnt_r - CNT_W'(1);
  assign new_ent = '{pa: req_r.pa, len: req_r.len, ha: req_r.ha};
  assign upd_ent = '{pa: hit_ent_r.pa, len: hit_ent_r.len, ha: req_r.ha};

  always_comb begin
    priority if (req_r.mode == MODE_ADD || req_r.mode == MODE_REMOVE) begin
      match = pa_eq && ha_eq;
    end else if (req_r.mode == MODE_FIND_PA) begin
      match = ha_eq;
    end else begin
      match = pa_eq;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    sh_idx_nxt     = sh_idx_r;
    rsp_nxt        = rsp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rsp_nxt    = out_rsp_r;
    st_req         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt        = in_req;
          req_nxt.pa     = pa_mask(in_req.pa, in_req.len);
          hit_nxt        = 1'b0;
          cmp_v_nxt      = 1'b0;
          issue_done_nxt = 1'b0;
          scan_idx_nxt   = last_c[IDX_W-1:0];
          rsp_nxt        = '0;
          priority if (in_req.mode > MODE_UPDATE) begin
            rsp_nxt.status = ST_INVALID;
            state_nxt      = S_FIN;
          end else if (len_bad) begin
            rsp_nxt.status = ST_INVALID;
            state_nxt      = S_FIN;
          end else if (in_req.ptype != table_ptype) begin
            rsp_nxt.status = ST_TYPE;
            state_nxt      = S_FIN;
          end else if (cnt_r == '0) begin
            state_nxt = S_ACT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // newest first: issue one read a cycle, compare the previous one
      S_SCAN: begin
        st_req.re    = !issue_done_r;
        st_req.raddr = scan_idx_r;
        cmp_v_nxt    = !issue_done_r;
        cmp_idx_nxt  = scan_idx_r;
        if (!issue_done_r) begin
          if (scan_idx_r == '0) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r - IDX_W'(1);
          end
        end
        if (cmp_v_r) begin
          if (match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hit_ent_nxt = rd_data;
            cmp_v_nxt   = 1'b0;
            state_nxt   = S_ACT;
          end else if (cmp_idx_r == '0) begin
            cmp_v_nxt = 1'b0;
            state_nxt = S_ACT;
          end
        end
      end

      S_ACT: begin
        state_nxt = S_FIN;
        rsp_nxt   = '0;
        unique case (req_r.mode)
          MODE_ADD: begin
            if (hit_r) begin
              rsp_nxt = {ST_OK, hit_ent_r};
            end else if (cnt_r == CNT_W'(TABLE_ENTRIES)) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              st_req.we    = 1'b1;
              st_req.waddr = cnt_r[IDX_W-1:0];
              st_req.wdata = new_ent;
              cnt_nxt      = cnt_r + CNT_W'(1);
              rsp_nxt      = {ST_OK, new_ent};
            end
          end
          MODE_REMOVE: begin
            if (!hit_r) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else begin
              rsp_nxt    = {ST_OK, hit_ent_r};
              sh_idx_nxt = hit_idx_r;
              if (CNT_W'(hit_idx_r) == last_c) begin
                cnt_nxt = last_c;
              end else begin
                st_req.re    = 1'b1;
                st_req.raddr = hit_idx_r + IDX_W'(1);
                state_nxt    = S_SHIFT;
              end
            end
          end
          MODE_FIND_PA, MODE_FIND_HA: begin
            if (hit_r) begin
              rsp_nxt = {ST_OK, hit_ent_r};
            end else begin
              rsp_nxt.status = ST_NOT_FOUND;
            end
          end
          MODE_UPDATE: begin
            if (hit_r) begin
              st_req.we    = 1'b1;
              st_req.waddr = hit_idx_r;
              st_req.wdata = upd_ent;
              rsp_nxt      = {ST_OK, upd_ent};
            end else begin
              rsp_nxt.status = ST_NOT_FOUND;
            end
          end
          default: begin
            rsp_nxt.status = ST_INVALID;
          end
        endcase
      end

      // move younger entries down one slot
      S_SHIFT: begin
        st_req.we    = 1'b1;
        st_req.waddr = sh_idx_r;
        st_req.wdata = rd_data;
        if (CNT_W'(sh_idx_r) + CNT_W'(1) == last_c) begin
          cnt_nxt   = last_c;
          state_nxt = S_FIN;
        end else begin
          sh_idx_nxt   = sh_idx_r + IDX_W'(1);
          st_req.re    = 1'b1;
          st_req.raddr = sh_idx_r + IDX_W'(2);
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = rsp_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      issue_done_r <= 1'b0;
      cmp_v_r      <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_v_r      <= cmp_v_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    sh_idx_r   <= sh_idx_nxt;
    rsp_r      <= rsp_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

endmodule

// ===== design/address_resolution_cache.sv =====
// Address resolution cache: up to TABLE_ENTRIES protocol/hardware address
// pairs for one protocol type, kept oldest first in a table with one read and one write port.
// in_ch takes one request item (mode, ptype, pa_value, pa_length, ha_value);
// out_ch returns exactly one result item per request.
// The APB port holds table_ptype at address 0; pready is always high.
// One item at a time: in_ch.ready is high only while the block is idle.
// Path from accept to out_ch.valid:
//   rejected request (bad mode, length or type): straight to the result
//   any request on an empty table: no scan, straight to the table action
//   lookup: entries scanned newest first, one per cycle, then the action
//   remove hit: then younger entries are shifted down one slot at a time
// The next item can be taken in the same cycle as the result appears.
// The table RAM (one read, one write port) sets the one-entry-per-cycle pace.
// Reset empties the table and clears table_ptype to zero.
// The result sits in an output register; a new item may be accepted while it
// waits. If out_ch stalls, the next result holds back until the slot frees.
module address_resolution_cache import arc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  arc_in_if.sink              in_ch,
  arc_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [PT_W-1:0] table_ptype_r;
  logic            reg_sel;
  req_t            in_req;
  rsp_t            out_rsp;
  store_req_t      st_req;
  entry_t          rd_data;

  assign reg_sel = (paddr[PADDR_W-1:2] == REG_TABLE_PTYPE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(table_ptype_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_ptype_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      table_ptype_r <= pwdata[PT_W-1:0];
    end
  end

  assign in_req = '{mode: in_ch.mode, ptype: in_ch.ptype, pa: in_ch.pa_value,
                    len: in_ch.pa_length, ha: in_ch.ha_value};

  assign out_ch.status          = out_rsp.status;
  assign out_ch.found_pa        = out_rsp.pa;
  assign out_ch.found_pa_length = out_rsp.len;
  assign out_ch.found_ha        = out_rsp.ha;

  arc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req      (in_req),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_rsp     (out_rsp),
    .table_ptype (table_ptype_r),
    .st_req      (st_req),
    .rd_data     (rd_data)
  );

  arc_store u_store (
    .clk     (clk),
    .st_req  (st_req),
    .rd_data (rd_data)
  );

endmodule

// ===== design/arc_checker.sv =====
`include "address_resolution_cache_defines.svh"

module arc_checker import arc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  out_status,
  input logic [PA_W-1:0]  out_found_pa,
  input logic [PAL_W-1:0] out_found_pa_length,
  input logic [HA_W-1:0]  out_found_ha
);

  `ARC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found_pa) && $stable(out_found_pa_length) && $stable(out_found_ha), "result item changed while stalled")
  `ARC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while still busy")
  `ARC_ASSERT_SAME(a_fail_zero, out_valid && out_status != ST_OK, out_found_pa == '0 && out_found_pa_length == '0 && out_found_ha == '0, "failed result carries address data")
  `ARC_ASSERT_SAME(a_ok_length, out_valid && out_status == ST_OK, out_found_pa_length != '0 && out_found_pa_length <= PAL_W'(PA_MAX_BYTES), "ok result with bad length")
  `ARC_ASSERT_SAME(a_status_code, out_valid, out_status <= ST_TYPE, "undefined status code")

endmodule

bind address_resolution_cache arc_checker u_arc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_status          (out_ch.status),
  .out_found_pa        (out_ch.found_pa),
  .out_found_pa_length (out_ch.found_pa_length),
  .out_found_ha        (out_ch.found_ha)
);
